// ===== design/msfe_pkg.sv =====
`default_nettype none

package msfe_pkg;

    // Sequencer states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEND
    } state_t;

    // Control of the CRC unit.
    typedef struct packed {
        logic init;
        logic step;
    } crc_ctrl_t;

    typedef logic [3:0] byte_idx_t;

    // Command codes.
    localparam logic [1:0] CMD_CTRL  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Sub-kind codes; their meaning depends on the command.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_1ST  = 2'd1;
    localparam logic [1:0] KIND_2ND  = 2'd2;
    localparam logic [1:0] KIND_3RD  = 2'd3;

    // Frame constants.
    localparam logic [7:0] FRAME_START = 8'h53;
    localparam logic [7:0] FRAME_END   = 8'h45;
    localparam logic [7:0] CRC_INIT    = 8'hFF;
    localparam logic [7:0] CRC_POLY    = 8'hD5;

    // Position of each fixed byte within a frame.
    localparam byte_idx_t BYTE_START  = 4'd0;
    localparam byte_idx_t BYTE_LEN    = 4'd1;
    localparam byte_idx_t BYTE_NODE   = 4'd2;
    localparam byte_idx_t BYTE_CMD    = 4'd3;
    localparam byte_idx_t BYTE_OBJ_LO = 4'd4;
    localparam byte_idx_t BYTE_OBJ_HI = 4'd5;
    localparam byte_idx_t BYTE_SUB    = 4'd6;
    localparam byte_idx_t BYTE_V0     = 4'd7;
    localparam byte_idx_t BYTE_V1     = 4'd8;
    localparam byte_idx_t BYTE_V2     = 4'd9;
    localparam byte_idx_t BYTE_V3     = 4'd10;

    // Index of the final byte ('E') for each frame type.
    localparam byte_idx_t LAST_CTRL  = 4'd7;
    localparam byte_idx_t LAST_WRITE = 4'd12;
    localparam byte_idx_t LAST_READ  = 4'd8;
    localparam byte_idx_t LAST_BAD   = 4'd0;

endpackage

`default_nettype wire

// ===== design/motor_serial_frame_encoder_top.sv =====
// The first frame byte enters the output register once the sequencer state
// register holds the send state. One frame byte per cycle while the output is
// not stalled; a request holds the sequencer until its last frame byte is loaded.
// The CRC unit absorbs one byte per cycle as that byte goes to the output register.
// Reset: sequencer idle, output register empty, node_id set to 1.
`default_nettype none

module motor_serial_frame_encoder_top
    import msfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [1:0]  kind,
    input  wire logic signed [31:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       frame_byte,
    output logic             last_byte,
    output logic             bad_kind,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    state_t      state_reg, state_next;
    logic [7:0]  node_reg;
    logic [1:0]  cmd_reg;
    logic [1:0]  kind_reg;
    logic [31:0] value_reg;
    logic        bad_reg;
    byte_idx_t   idx_reg, idx_next;
    byte_idx_t   last_idx;
    logic        out_valid_reg;
    logic [7:0]  frame_byte_reg;
    logic        last_byte_reg;
    logic        bad_kind_reg;
    logic        accept;
    logic        load_out;
    logic        in_bad;
    logic [7:0]  table_byte;
    logic [7:0]  send_byte;
    logic [7:0]  crc;
    crc_ctrl_t   crc_ctrl;

    // Configuration register; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_reg <= 8'd1;
        else if (cfg_valid)
            node_reg <= cfg_data;
    end

    // Sub-kind check of the incoming request.
    always_comb
    begin
        case (cmd)
            CMD_CTRL:  in_bad = (kind == KIND_NONE);
            CMD_WRITE: in_bad = !(kind inside {KIND_1ST, KIND_2ND});
            CMD_READ:  in_bad = (kind == KIND_NONE);
            default:   in_bad = 1'b1;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        load_out = (state_reg == ST_SEND) && (!out_valid_reg || out_ready);
    end

    assign accept = in_valid && in_ready;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (load_out && (idx_reg == last_idx))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Byte counter.
    always_comb
    begin
        if (accept)
            idx_next = BYTE_START;
        else if (load_out)
            idx_next = idx_reg + 4'd1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= BYTE_START;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            kind_reg  <= kind;
            value_reg <= value;
            bad_reg   <= in_bad;
        end
    end

    // Index of the closing byte of the current frame.
    always_comb
    begin
        if (bad_reg)
            last_idx = LAST_BAD;
        else
        begin
            case (cmd_reg)
                CMD_CTRL:  last_idx = LAST_CTRL;
                CMD_WRITE: last_idx = LAST_WRITE;
                CMD_READ:  last_idx = LAST_READ;
                default:   last_idx = LAST_BAD;
            endcase
        end
    end

    // Header and payload byte at the current position.
    always_comb
    begin
        table_byte = 8'h00;
        case (idx_reg)
            BYTE_START: table_byte = FRAME_START;
            BYTE_LEN:
            begin
                case (cmd_reg)
                    CMD_CTRL:  table_byte = 8'h06;
                    CMD_WRITE: table_byte = 8'h0A;
                    default:   table_byte = 8'h07;
                endcase
            end
            BYTE_NODE: table_byte = node_reg;
            BYTE_CMD:
            begin
                case (cmd_reg)
                    CMD_CTRL:  table_byte = 8'h04;
                    CMD_WRITE: table_byte = 8'h02;
                    default:   table_byte = 8'h01;
                endcase
            end
            BYTE_OBJ_LO:
            begin
                case (cmd_reg)
                    CMD_CTRL:
                    begin
                        case (kind_reg)
                            KIND_1ST: table_byte = 8'h06;
                            KIND_2ND: table_byte = 8'h07;
                            default:  table_byte = 8'h0F;
                        endcase
                    end
                    CMD_WRITE: table_byte = (kind_reg == KIND_1ST) ? 8'hFF : 8'h7A;
                    default:
                    begin
                        case (kind_reg)
                            KIND_1ST: table_byte = 8'h77;
                            KIND_2ND: table_byte = 8'h6C;
                            default:  table_byte = 8'h64;
                        endcase
                    end
                endcase
            end
            BYTE_OBJ_HI: table_byte = (cmd_reg == CMD_CTRL) ? 8'h00 : 8'h60;
            BYTE_SUB:    table_byte = 8'h00;
            BYTE_V0:     table_byte = value_reg[7:0];
            BYTE_V1:     table_byte = value_reg[15:8];
            BYTE_V2:     table_byte = value_reg[23:16];
            BYTE_V3:     table_byte = value_reg[31:24];
            default:     table_byte = 8'h00;
        endcase
    end

    // Final byte selection: error marker, closing byte, CRC or table byte.
    always_comb
    begin
        if (bad_reg)
            send_byte = 8'h00;
        else if (idx_reg == last_idx)
            send_byte = FRAME_END;
        else if (idx_reg == last_idx - 4'd1)
            send_byte = crc;
        else
            send_byte = table_byte;
    end

    // The CRC covers every byte from the length byte up to the one before the CRC.
    always_comb
    begin
        crc_ctrl.init = accept;
        crc_ctrl.step = load_out && !bad_reg && (idx_reg != BYTE_START)
                        && (idx_reg < last_idx - 4'd1);
    end

    msfe_crc8 u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (table_byte),
        .crc   (crc)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            frame_byte_reg <= send_byte;
            last_byte_reg  <= (idx_reg == last_idx);
            bad_kind_reg   <= bad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last_byte  = last_byte_reg;
    assign bad_kind   = bad_kind_reg;

endmodule

`default_nettype wire

// ===== design/msfe_crc8.sv =====
`default_nettype none

module msfe_crc8
    import msfe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire crc_ctrl_t ctrl,
    input  wire logic [7:0] data,
    output logic [7:0]     crc
);

    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    // Reflected CRC-8 update of one byte, LSB first.
    function automatic logic [7:0] crc_byte(input logic [7:0] c_in, input logic [7:0] b);
        logic [7:0] c;
        c = c_in ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Next value: restart, absorb one byte, or hold.
    always_comb
    begin
        if (ctrl.init)
            crc_next = CRC_INIT;
        else if (ctrl.step)
            crc_next = crc_byte(crc_reg, data);
        else
            crc_next = crc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire

// ===== design/msfe_checker.sv =====
`default_nettype none

module msfe_checker
    import msfe_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] frame_byte,
    input wire logic       last_byte,
    input wire logic       bad_kind
);

    // A stalled output beat keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte)
                                    && $stable(last_byte) && $stable(bad_kind))
        else $error("output beat changed while stalled");

    // A rejected request is reported as one zero beat that closes it.
    a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_kind |-> last_byte && (frame_byte == 8'h00))
        else $error("malformed error beat");

    // A good frame always closes with the end marker.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte && !bad_kind |-> frame_byte == FRAME_END)
        else $error("frame did not close with end marker");

    // The block is not ready in the cycle after it takes a request.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

endmodule

bind motor_serial_frame_encoder_top msfe_checker u_msfe_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .bad_kind   (bad_kind)
);

`default_nettype wire
